// ----- rtl/vss_pkg.sv -----
package vss_pkg;

  localparam int Lanes    = 4;
  localparam int LaneIdxW = 2;
  localparam int LaneCntW = 3;
  localparam int ElemW    = 16;
  localparam int ProdW    = 2 * ElemW;
  localparam int AccW     = 48;
  localparam int TotW     = 13;
  localparam int MaxDim   = 4096;
  localparam int FracOut  = 30;
  localparam int WideW    = 2 * AccW;
  localparam int NumW     = AccW + FracOut;
  localparam int StepW    = 7;

  localparam logic [1:0] MetricCos  = 2'd0;
  localparam logic [1:0] MetricDot  = 2'd1;
  localparam logic [1:0] MetricEuc  = 2'd2;
  localparam logic [1:0] MetricNone = 2'd3;

  typedef struct packed {
    logic signed [ProdW-1:0] dot;
    logic [ProdW-1:0]        aa;
    logic [ProdW-1:0]        bb;
    logic [ProdW-1:0]        dd;
  } lane_prod_t;

  typedef struct packed {
    logic signed [AccW-1:0] dot;
    logic [AccW-1:0]        na;
    logic [AccW-1:0]        nb;
    logic [AccW-1:0]        dsq;
    logic                   clip;
  } snap_t;

endpackage

// ----- rtl/vss_if.sv -----
interface vss_req_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [vss_pkg::ElemW-1:0]     a_lane0;
  logic signed [vss_pkg::ElemW-1:0]     a_lane1;
  logic signed [vss_pkg::ElemW-1:0]     a_lane2;
  logic signed [vss_pkg::ElemW-1:0]     a_lane3;
  logic signed [vss_pkg::ElemW-1:0]     b_lane0;
  logic signed [vss_pkg::ElemW-1:0]     b_lane1;
  logic signed [vss_pkg::ElemW-1:0]     b_lane2;
  logic signed [vss_pkg::ElemW-1:0]     b_lane3;
  logic [vss_pkg::LaneCntW-1:0]         lanes_used;
  logic                                 last;
  modport source (output valid, a_lane0, a_lane1, a_lane2, a_lane3, b_lane0, b_lane1,
                  b_lane2, b_lane3, lanes_used, last, input ready);
  modport sink (input valid, a_lane0, a_lane1, a_lane2, a_lane3, b_lane0, b_lane1,
                b_lane2, b_lane3, lanes_used, last, output ready);
endinterface

interface vss_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [vss_pkg::AccW-1:0]  similarity;
  logic                             saturated;
  modport source (output valid, similarity, saturated, input ready);
  modport sink (input valid, similarity, saturated, output ready);
endinterface

interface vss_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] metric;
  modport source (output valid, metric, input ready);
  modport sink (input valid, metric, output ready);
endinterface

// ----- rtl/vss_lane.sv -----
module vss_lane (
  input  logic                              clk_i,
  input  logic                              load_i,
  input  logic signed [vss_pkg::ElemW-1:0]  a_i,
  input  logic signed [vss_pkg::ElemW-1:0]  b_i,
  output vss_pkg::lane_prod_t               prod_o
);

  logic signed [vss_pkg::ProdW-1:0]   ab;
  logic signed [vss_pkg::ProdW-1:0]   aa;
  logic signed [vss_pkg::ProdW-1:0]   bb;
  logic signed [vss_pkg::ElemW:0]     diff;
  logic signed [vss_pkg::ProdW+1:0]   dd;
  vss_pkg::lane_prod_t                prod_d, prod_q;

  assign ab   = a_i * b_i;
  assign aa   = a_i * a_i;
  assign bb   = b_i * b_i;
  assign diff = (vss_pkg::ElemW+1)'(a_i) - (vss_pkg::ElemW+1)'(b_i);
  assign dd   = diff * diff;

  always_comb begin
    prod_d.dot = ab;
    prod_d.aa  = unsigned'(aa);
    prod_d.bb  = unsigned'(bb);
    // |a-b| stays below 2^16, so the square fits the low bits
    prod_d.dd  = unsigned'(dd[vss_pkg::ProdW-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ----- rtl/vss_acc.sv -----
module vss_acc (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [vss_pkg::LaneCntW-1:0]  n_i,
  input  logic                          last_i,
  input  vss_pkg::lane_prod_t           prod_i [vss_pkg::Lanes],
  input  logic                          be_ready_i,
  output logic                          busy_o,
  output logic                          hand_o,
  output vss_pkg::snap_t                snap_o
);

  typedef enum logic [1:0] {StIdle, StFold, StHand} state_e;

  state_e                               state_q;
  logic [vss_pkg::LaneCntW-1:0]         idx_q, n_q;
  logic                                 last_q;
  logic signed [vss_pkg::AccW-1:0]      dot_q;
  logic [vss_pkg::AccW-1:0]             na_q, nb_q, dsq_q;
  logic [vss_pkg::TotW-1:0]             tot_q;
  logic                                 clip_q;

  vss_pkg::lane_prod_t                  sel;
  logic signed [vss_pkg::AccW:0]        dot_s;
  logic [vss_pkg::AccW:0]               na_s, nb_s, dsq_s;
  logic signed [vss_pkg::AccW-1:0]      dot_d;
  logic [vss_pkg::AccW-1:0]             na_d, nb_d, dsq_d;
  logic                                 ovf_d;
  logic                                 full;

  localparam logic [vss_pkg::AccW-1:0] PosMax = {1'b0, {(vss_pkg::AccW-1){1'b1}}};
  localparam logic [vss_pkg::AccW-1:0] NegMin = {1'b1, {(vss_pkg::AccW-1){1'b0}}};

  assign sel  = prod_i[idx_q[vss_pkg::LaneIdxW-1:0]];
  assign full = tot_q >= vss_pkg::TotW'(vss_pkg::MaxDim);

  always_comb begin
    dot_s = (vss_pkg::AccW+1)'(dot_q) + (vss_pkg::AccW+1)'(sel.dot);
    na_s  = {1'b0, na_q} + (vss_pkg::AccW+1)'(sel.aa);
    nb_s  = {1'b0, nb_q} + (vss_pkg::AccW+1)'(sel.bb);
    dsq_s = {1'b0, dsq_q} + (vss_pkg::AccW+1)'(sel.dd);
    ovf_d = 1'b0;
    if (dot_s[vss_pkg::AccW] != dot_s[vss_pkg::AccW-1]) begin
      dot_d = dot_s[vss_pkg::AccW] ? signed'(NegMin) : signed'(PosMax);
      ovf_d = 1'b1;
    end else begin
      dot_d = dot_s[vss_pkg::AccW-1:0];
    end
    // norms never go negative: only the top clamp applies
    if (na_s[vss_pkg::AccW-1]) begin
      na_d = PosMax;
      ovf_d = 1'b1;
    end else begin
      na_d = na_s[vss_pkg::AccW-1:0];
    end
    if (nb_s[vss_pkg::AccW-1]) begin
      nb_d = PosMax;
      ovf_d = 1'b1;
    end else begin
      nb_d = nb_s[vss_pkg::AccW-1:0];
    end
    if (dsq_s[vss_pkg::AccW-1]) begin
      dsq_d = PosMax;
      ovf_d = 1'b1;
    end else begin
      dsq_d = dsq_s[vss_pkg::AccW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
      n_q     <= '0;
      last_q  <= 1'b0;
      dot_q   <= '0;
      na_q    <= '0;
      nb_q    <= '0;
      dsq_q   <= '0;
      tot_q   <= '0;
      clip_q  <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (start_i) begin
            idx_q   <= '0;
            n_q     <= n_i;
            last_q  <= last_i;
            state_q <= StFold;
          end
        end
        StFold: begin
          if (idx_q < n_q) begin
            idx_q <= idx_q + 1'b1;
            if (full) begin
              // drop elements past the maximum dimension
              clip_q <= 1'b1;
            end else begin
              dot_q  <= dot_d;
              na_q   <= na_d;
              nb_q   <= nb_d;
              dsq_q  <= dsq_d;
              tot_q  <= tot_q + 1'b1;
              clip_q <= clip_q | ovf_d;
            end
          end else begin
            state_q <= last_q ? StHand : StIdle;
          end
        end
        StHand: begin
          if (be_ready_i) begin
            dot_q   <= '0;
            na_q    <= '0;
            nb_q    <= '0;
            dsq_q   <= '0;
            tot_q   <= '0;
            clip_q  <= 1'b0;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o      = state_q != StIdle;
  assign hand_o      = (state_q == StHand) && be_ready_i;
  assign snap_o.dot  = dot_q;
  assign snap_o.na   = na_q;
  assign snap_o.nb   = nb_q;
  assign snap_o.dsq  = dsq_q;
  assign snap_o.clip = clip_q;

endmodule

// ----- rtl/vss_backend.sv -----
module vss_backend (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              hand_i,
  input  logic [1:0]                        metric_i,
  input  vss_pkg::snap_t                    snap_i,
  output logic                              ready_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [vss_pkg::AccW-1:0]   sim_o,
  output logic                              sat_o
);

  typedef enum logic [2:0] {StIdle, StMul, StSqrt, StPost, StDiv, StClamp, StFin} state_e;

  localparam int AccW = vss_pkg::AccW;
  localparam logic [AccW-1:0] PosMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic [AccW-1:0] NegMin = {1'b1, {(AccW-1){1'b0}}};

  state_e                          state_q;
  logic [1:0]                      met_q;
  logic                            neg_q, clip_q, rclip_q;
  logic [AccW-1:0]                 mag_q, mula_q, mulb_q, root_q;
  logic [vss_pkg::WideW-1:0]       wide_q;
  logic [AccW+1:0]                 rem_q;
  logic [vss_pkg::NumW-1:0]        num_q, quo_q;
  logic [vss_pkg::StepW-1:0]       cnt_q;
  logic [AccW-1:0]                 res_q;
  logic                            ov_q, osat_q;
  logic [AccW-1:0]                 osim_q;

  logic [AccW+1:0]                 sq_rem, sq_trial;
  logic [AccW:0]                   dv_rem;

  assign sq_rem   = {rem_q[AccW-1:0], wide_q[vss_pkg::WideW-1 -: 2]};
  assign sq_trial = {root_q, 2'b01};
  assign dv_rem   = {rem_q[AccW-1:0], num_q[vss_pkg::NumW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
      met_q   <= '0;
      neg_q   <= 1'b0;
      clip_q  <= 1'b0;
      rclip_q <= 1'b0;
      mag_q   <= '0;
      mula_q  <= '0;
      mulb_q  <= '0;
      root_q  <= '0;
      wide_q  <= '0;
      rem_q   <= '0;
      num_q   <= '0;
      quo_q   <= '0;
      cnt_q   <= '0;
      res_q   <= '0;
      osim_q  <= '0;
      osat_q  <= 1'b0;
    end else begin
      if (ov_q && out_ready_i && (state_q != StFin)) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (hand_i) begin
            met_q   <= metric_i;
            clip_q  <= snap_i.clip;
            rclip_q <= 1'b0;
            neg_q   <= snap_i.dot[AccW-1];
            mag_q   <= snap_i.dot[AccW-1] ? unsigned'(-snap_i.dot) : unsigned'(snap_i.dot);
            cnt_q   <= '0;
            rem_q   <= '0;
            root_q  <= '0;
            case (metric_i)
              vss_pkg::MetricCos: begin
                mula_q  <= snap_i.na;
                mulb_q  <= snap_i.nb;
                wide_q  <= '0;
                state_q <= StMul;
              end
              vss_pkg::MetricDot: begin
                res_q   <= unsigned'(snap_i.dot);
                state_q <= StFin;
              end
              vss_pkg::MetricEuc: begin
                wide_q  <= {{(vss_pkg::WideW-vss_pkg::NumW){1'b0}}, snap_i.dsq,
                            {vss_pkg::FracOut{1'b0}}};
                state_q <= StSqrt;
              end
              default: begin
                res_q   <= '0;
                state_q <= StFin;
              end
            endcase
          end
        end
        StMul: begin
          // shift-add, multiplier bits taken msb first
          wide_q <= {wide_q[vss_pkg::WideW-2:0], 1'b0} +
                    (mulb_q[AccW-1] ? {{AccW{1'b0}}, mula_q} : '0);
          mulb_q <= {mulb_q[AccW-2:0], 1'b0};
          if (cnt_q == vss_pkg::StepW'(AccW - 1)) begin
            cnt_q   <= '0;
            state_q <= StSqrt;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StSqrt: begin
          // one root bit per cycle from the top two radicand bits
          if (sq_rem >= sq_trial) begin
            rem_q  <= sq_rem - sq_trial;
            root_q <= {root_q[AccW-2:0], 1'b1};
          end else begin
            rem_q  <= sq_rem;
            root_q <= {root_q[AccW-2:0], 1'b0};
          end
          wide_q <= {wide_q[vss_pkg::WideW-3:0], 2'b00};
          if (cnt_q == vss_pkg::StepW'(AccW - 1)) begin
            cnt_q   <= '0;
            state_q <= StPost;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StPost: begin
          if (met_q == vss_pkg::MetricEuc) begin
            res_q   <= -root_q;
            state_q <= StFin;
          end else if (root_q == '0) begin
            res_q   <= '0;
            state_q <= StFin;
          end else begin
            num_q   <= {mag_q, {vss_pkg::FracOut{1'b0}}};
            quo_q   <= '0;
            rem_q   <= '0;
            state_q <= StDiv;
          end
        end
        StDiv: begin
          if (dv_rem >= {1'b0, root_q}) begin
            rem_q <= (AccW+2)'(dv_rem - {1'b0, root_q});
            quo_q <= {quo_q[vss_pkg::NumW-2:0], 1'b1};
          end else begin
            rem_q <= (AccW+2)'(dv_rem);
            quo_q <= {quo_q[vss_pkg::NumW-2:0], 1'b0};
          end
          num_q <= {num_q[vss_pkg::NumW-2:0], 1'b0};
          if (cnt_q == vss_pkg::StepW'(vss_pkg::NumW - 1)) begin
            cnt_q   <= '0;
            state_q <= StClamp;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StClamp: begin
          if (!neg_q) begin
            if (quo_q > vss_pkg::NumW'(PosMax)) begin
              res_q   <= PosMax;
              rclip_q <= 1'b1;
            end else begin
              res_q <= quo_q[AccW-1:0];
            end
          end else begin
            if (quo_q > vss_pkg::NumW'(NegMin)) begin
              res_q   <= NegMin;
              rclip_q <= 1'b1;
            end else begin
              res_q <= -quo_q[AccW-1:0];
            end
          end
          state_q <= StFin;
        end
        StFin: begin
          // hold the result until the output register frees up
          if (!ov_q || out_ready_i) begin
            osim_q  <= res_q;
            osat_q  <= clip_q | rclip_q;
            ov_q    <= 1'b1;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign ready_o     = state_q == StIdle;
  assign out_valid_o = ov_q;
  assign sim_o       = signed'(osim_q);
  assign sat_o       = osat_q;

endmodule

// ----- rtl/vector_similarity_score_core.sv -----
// Streaming vector similarity.
// req_i carries up to four signed Q1.15 element pairs per request plus a lane
// count and a last flag; rsp_o returns one 48-bit score (30 fraction bits) and
// a saturation flag for each request marked last. cfg_i writes the metric
// register (cosine, dot, negative euclidean, other gives zero); write it only
// while the block is idle. cfg_i is always ready.
// Throughput: four lane multipliers work on a request in parallel (lane count
// capped at four), then one saturating accumulator folds one lane per cycle,
// taking no new request meanwhile; a last request then waits for the back end.
// After the hand-off to the back end, dot and unsupported metrics go straight
// to the output; euclidean runs a 48-step root; cosine runs a 48-step shift-add
// multiply, a 48-step root and a 78-step divide, all through one sequential
// back end.
// A finished score sits in an output register; while it waits the block keeps
// taking requests, and a later score waits in the back end, which then stalls
// the next last request.
// Reset clears all accumulators, the metric (to cosine) and the output valid.
module vector_similarity_score_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  vss_req_if.sink  req_i,
  vss_rsp_if.source rsp_o,
  vss_cfg_if.sink  cfg_i
);

  logic [1:0]                        metric_q;
  logic                              req_acc;
  logic [vss_pkg::LaneCntW-1:0]      n_clamp;
  logic                              acc_busy, hand, be_ready;
  vss_pkg::snap_t                    snap;
  vss_pkg::lane_prod_t               prod [vss_pkg::Lanes];
  logic signed [vss_pkg::ElemW-1:0]  a_vec [vss_pkg::Lanes];
  logic signed [vss_pkg::ElemW-1:0]  b_vec [vss_pkg::Lanes];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= vss_pkg::MetricCos;
    end else if (cfg_i.valid) begin
      metric_q <= cfg_i.metric;
    end
  end

  assign req_i.ready = !acc_busy;
  assign req_acc     = req_i.valid && !acc_busy;
  assign n_clamp     = (req_i.lanes_used > vss_pkg::LaneCntW'(vss_pkg::Lanes)) ?
                       vss_pkg::LaneCntW'(vss_pkg::Lanes) : req_i.lanes_used;

  assign a_vec[0] = req_i.a_lane0;
  assign a_vec[1] = req_i.a_lane1;
  assign a_vec[2] = req_i.a_lane2;
  assign a_vec[3] = req_i.a_lane3;
  assign b_vec[0] = req_i.b_lane0;
  assign b_vec[1] = req_i.b_lane1;
  assign b_vec[2] = req_i.b_lane2;
  assign b_vec[3] = req_i.b_lane3;

  for (genvar g = 0; g < vss_pkg::Lanes; g++) begin : g_lane
    vss_lane u_lane (
      .clk_i  (clk_i),
      .load_i (req_acc),
      .a_i    (a_vec[g]),
      .b_i    (b_vec[g]),
      .prod_o (prod[g])
    );
  end

  vss_acc u_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (req_acc),
    .n_i        (n_clamp),
    .last_i     (req_i.last),
    .prod_i     (prod),
    .be_ready_i (be_ready),
    .busy_o     (acc_busy),
    .hand_o     (hand),
    .snap_o     (snap)
  );

  vss_backend u_backend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hand_i      (hand),
    .metric_i    (metric_q),
    .snap_i      (snap),
    .ready_o     (be_ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sim_o       (rsp_o.similarity),
    .sat_o       (rsp_o.saturated)
  );

endmodule

// ----- dv/vss_score_checker.sv -----
`timescale 1ns / 100ps

module vss_score_checker (
  input  logic clk_i,
  input  logic rst_ni,
  vss_req_if   req,
  vss_rsp_if   rsp,
  vss_cfg_if   cfg,
  output int   errors_o,
  output int   pending_o
);
  import vss_pkg::*;

  localparam longint ScoreMax = (64'sd1 <<< 47) - 1;
  localparam longint ScoreMin = -ScoreMax - 1;

  typedef struct {
    logic [AccW-1:0] similarity;
    logic            saturated;
  } score_t;

  score_t       score_q[$];
  logic [1:0]   metric;
  longint       dot_acc, na_acc, nb_acc, dsq_acc;
  int           elem_cnt;
  logic         clip_flag;

  function automatic logic [63:0] floor_sqrt(logic [127:0] x);
    logic [63:0]  r;
    logic [127:0] t;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      t = {64'd0, r | (64'd1 << k)};
      if (t * t <= x) r = t[63:0];
    end
    return r;
  endfunction

  function automatic longint add_mag(longint acc, longint p, ref logic clip);
    if (p > ScoreMax - acc) begin
      clip = 1'b1;
      return ScoreMax;
    end
    return acc + p;
  endfunction

  // Fold one request into the sums; produce a score when last is set.
  task automatic fold_request(output bit has_score, output score_t s);
    longint       a[4], b[4], d, p;
    int           n;
    logic [127:0] wide, num, q;
    logic [63:0]  den, mag;
    longint       res;
    logic         rclip;
    a[0] = req.a_lane0; a[1] = req.a_lane1; a[2] = req.a_lane2; a[3] = req.a_lane3;
    b[0] = req.b_lane0; b[1] = req.b_lane1; b[2] = req.b_lane2; b[3] = req.b_lane3;
    n = (req.lanes_used > Lanes) ? Lanes : req.lanes_used;
    for (int i = 0; i < n; i++) begin
      if (elem_cnt >= MaxDim) begin
        clip_flag = 1'b1;
        continue;
      end
      p = dot_acc + a[i] * b[i];
      if (p > ScoreMax) begin p = ScoreMax; clip_flag = 1'b1; end
      if (p < ScoreMin) begin p = ScoreMin; clip_flag = 1'b1; end
      dot_acc = p;
      na_acc  = add_mag(na_acc, a[i] * a[i], clip_flag);
      nb_acc  = add_mag(nb_acc, b[i] * b[i], clip_flag);
      d       = a[i] - b[i];
      dsq_acc = add_mag(dsq_acc, d * d, clip_flag);
      elem_cnt++;
    end
    has_score = req.last;
    if (!req.last) return;
    res   = 0;
    rclip = 1'b0;
    case (metric)
      MetricCos: begin
        wide = 128'(na_acc) * 128'(nb_acc);
        den  = floor_sqrt(wide);
        if (den != 0) begin
          mag = (dot_acc < 0) ? 64'(-dot_acc) : 64'(dot_acc);
          num = 128'(mag) << FracOut;
          q   = num / 128'(den);
          if (dot_acc >= 0) begin
            if (q > 128'(ScoreMax)) begin res = ScoreMax; rclip = 1'b1; end
            else res = longint'(q[63:0]);
          end else begin
            if (q > 128'(ScoreMax) + 1) begin res = ScoreMin; rclip = 1'b1; end
            else res = -longint'(q[63:0]);
          end
        end
      end
      MetricDot: res = dot_acc;
      MetricEuc: res = -longint'(floor_sqrt(128'(dsq_acc) << FracOut));
      default:   res = 0;
    endcase
    s.similarity = res[AccW-1:0];
    s.saturated  = clip_flag | rclip;
    dot_acc = 0; na_acc = 0; nb_acc = 0; dsq_acc = 0;
    elem_cnt = 0;
    clip_flag = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bit     got;
    score_t s, want;
    if (!rst_ni) begin
      metric = MetricCos;
      dot_acc = 0; na_acc = 0; nb_acc = 0; dsq_acc = 0;
      elem_cnt = 0;
      clip_flag = 1'b0;
      score_q.delete();
      errors_o = 0;
    end else begin
      if (cfg.valid && cfg.ready) metric = cfg.metric;
      if (req.valid && req.ready) begin
        fold_request(got, s);
        if (got) score_q.push_back(s);
      end
      if (rsp.valid && rsp.ready) begin
        if (score_q.size() == 0) begin
          $display("%0t: unexpected score %h sat %b", $time, rsp.similarity, rsp.saturated);
          errors_o++;
        end else begin
          want = score_q.pop_front();
          if (rsp.similarity !== want.similarity) begin
            $display("%0t: similarity expected %h actual %h", $time, want.similarity,
                     rsp.similarity);
            errors_o++;
          end
          if (rsp.saturated !== want.saturated) begin
            $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                     rsp.saturated);
            errors_o++;
          end
        end
      end
    end
    pending_o = score_q.size();
  end

endmodule

// ----- dv/tb_vector_similarity_score_core.sv -----
`timescale 1ns / 100ps

module tb_vector_similarity_score_core;
  import vss_pkg::*;

  localparam int DrainCycles = 400;
  localparam int CycleLimit  = 2000000;

  logic clk_i;
  logic rst_ni;
  int   errors, pending, cycle_cnt;
  int   burst_left;
  int   hold_cycles;
  int   rx_mode, rx_left;

  vss_req_if req ();
  vss_rsp_if rsp ();
  vss_cfg_if cfg ();

  vector_similarity_score_core u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp),
    .cfg_i (cfg)
  );

  vss_score_checker u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req      (req),
    .rsp      (rsp),
    .cfg      (cfg),
    .errors_o (errors),
    .pending_o(pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("FAIL vector_similarity_score_core");
      $finish;
    end
  end

  // Result side: long hold on demand, otherwise a changing stall pattern.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      rsp.ready <= 1'b0;
      hold_cycles--;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
        0:       rsp.ready <= 1'b1;
        1:       rsp.ready <= 1'($urandom_range(0, 1));
        default: rsp.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  function automatic logic [ElemW-1:0] pick_elem();
    case ($urandom_range(0, 7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return ElemW'($urandom());
    endcase
  endfunction

  task automatic offer(input logic [ElemW-1:0] ea[4], input logic [ElemW-1:0] eb[4],
                       input logic [2:0] n, input logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk_i);
        req.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    req.valid      <= 1'b1;
    req.a_lane0    <= ea[0];
    req.a_lane1    <= ea[1];
    req.a_lane2    <= ea[2];
    req.a_lane3    <= ea[3];
    req.b_lane0    <= eb[0];
    req.b_lane1    <= eb[1];
    req.b_lane2    <= eb[2];
    req.b_lane3    <= eb[3];
    req.lanes_used <= n;
    req.last       <= lst;
    do @(posedge clk_i); while (!req.ready);
  endtask

  task automatic offer_fill(input logic [ElemW-1:0] va, input logic [ElemW-1:0] vb,
                            input logic [2:0] n, input logic lst);
    logic [ElemW-1:0] ea[4], eb[4];
    for (int i = 0; i < 4; i++) begin
      ea[i] = va;
      eb[i] = vb;
    end
    offer(ea, eb, n, lst);
  endtask

  task automatic offer_random(input logic lst);
    logic [ElemW-1:0] ea[4], eb[4];
    for (int i = 0; i < 4; i++) begin
      ea[i] = pick_elem();
      eb[i] = pick_elem();
    end
    offer(ea, eb, 3'($urandom_range(0, 7)), lst);
  endtask

  task automatic drain();
    @(negedge clk_i);
    req.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_metric(input logic [1:0] m);
    drain();
    @(negedge clk_i);
    cfg.valid  <= 1'b1;
    cfg.metric <= m;
    do @(posedge clk_i); while (!cfg.ready);
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  task automatic random_vectors(input int items);
    int len;
    while (items > 0) begin
      // mostly well-formed vectors, a few stray single requests
      len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 16);
      for (int k = 1; k <= len; k++) offer_random(k == len);
      items -= len;
    end
  endtask

  initial begin
    logic [1:0] order[6];
    clk_i = 1'b0;
    rst_ni = 1'b0;
    burst_left = 0;
    hold_cycles = 0;
    rx_left = 0;
    req.valid = 1'b0;
    req.a_lane0 = '0; req.a_lane1 = '0; req.a_lane2 = '0; req.a_lane3 = '0;
    req.b_lane0 = '0; req.b_lane1 = '0; req.b_lane2 = '0; req.b_lane3 = '0;
    req.lanes_used = '0;
    req.last = 1'b0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.metric = MetricCos;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed extremes for every metric, including the unsupported one.
    for (int m = 0; m < 4; m++) begin
      write_metric(m[1:0]);
      offer_fill(16'h7fff, 16'h7fff, 3'd4, 1'b0);
      offer_fill(16'h8000, 16'h8000, 3'd4, 1'b1);
      offer_fill(16'h0000, 16'h0000, 3'd4, 1'b1);
      offer_fill(16'h8000, 16'h7fff, 3'd7, 1'b1);
      offer_fill(16'h1234, 16'hedcb, 3'd0, 1'b1);
      offer_fill(16'h7fff, 16'h8000, 3'd5, 1'b1);
    end

    // Over-long vector: elements past the limit are dropped.
    write_metric(MetricDot);
    for (int k = 0; k < 1030; k++) offer_fill(pick_elem(), pick_elem(), 3'd4, k == 1029);

    order = '{MetricCos, MetricDot, MetricEuc, MetricNone, MetricCos, MetricEuc};
    for (int ph = 0; ph < 6; ph++) begin
      write_metric(order[ph]);
      if (ph == 1) begin
        // hold results off so the block backs up into its input
        @(negedge clk_i);
        hold_cycles = 800;
      end
      random_vectors(ph == 1 ? 200 : 110);
    end

    drain();
    if (errors == 0) begin
      $display("PASS vector_similarity_score_core");
    end else begin
      $display("FAIL vector_similarity_score_core");
    end
    $finish;
  end

endmodule
